[hdl/homogeneous_point_transform_macros.svh]
// Assertion macros shared by the checker of the homogeneous point transform.
// No dependencies; included by the checker file only.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle port check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle port check failed");

`endif

[hdl/hpt_pkg.sv]
// Shared types and constants of the homogeneous point transform.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

    localparam int REQ_TYPE_W  = 2;
    localparam int ENTRY_IDX_W = 4;
    localparam int NUM_ENTRIES = 16;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLS    = 4;
    localparam int NUM_LANES   = 3;
    localparam int W_ROW       = 3;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_LOAD      = 2'd0,
        REQ_POINT     = 2'd1,
        REQ_DIRECTION = 2'd2,
        REQ_RESERVED  = 2'd3
    } req_type_t;

    // Control that travels down the pipeline beside the data.
    typedef struct packed {
        logic valid;
        logic point;
        logic divide;
    } hpt_ctrl_t;

endpackage

`default_nettype wire

[hdl/hpt_mac.sv]
// Matrix store and the multiply-accumulate stages of the point transform.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpt_mac #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                take,
    input  logic [hpt_pkg::REQ_TYPE_W-1:0]      req_type,
    input  logic [hpt_pkg::ENTRY_IDX_W-1:0]     entry_index,
    input  logic signed [VALUE_WIDTH-1:0]       entry_value,
    input  logic signed [VALUE_WIDTH-1:0]       coord_x,
    input  logic signed [VALUE_WIDTH-1:0]       coord_y,
    input  logic signed [VALUE_WIDTH-1:0]       coord_z,
    output hpt_pkg::hpt_ctrl_t                  ctrl_out,
    output logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] row_out [hpt_pkg::NUM_LANES],
    output logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] mag_out [hpt_pkg::NUM_LANES],
    output logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] den_out,
    output logic                                den_neg_out
);
    import hpt_pkg::*;

    localparam int PW = 2 * VALUE_WIDTH;
    localparam int SW = PW + 2;
    localparam int RW = SW - FRAC_BITS;

    logic signed [VALUE_WIDTH-1:0] store_reg [NUM_ENTRIES];
    logic signed [VALUE_WIDTH-1:0] coord [NUM_LANES];

    hpt_ctrl_t ctrl_a_reg, ctrl_a_next, ctrl_b_reg, ctrl_c_reg, ctrl_d_reg, ctrl_d_next;

    logic signed [PW-1:0]          prod_a_reg  [NUM_ROWS][NUM_LANES];
    logic signed [PW-1:0]          prod_a_next [NUM_ROWS][NUM_LANES];
    logic signed [VALUE_WIDTH-1:0] trans_a_reg  [NUM_ROWS];
    logic signed [VALUE_WIDTH-1:0] trans_a_next [NUM_ROWS];
    logic signed [SW-1:0]          pa_b_reg [NUM_ROWS];
    logic signed [SW-1:0]          pa_b_next [NUM_ROWS];
    logic signed [SW-1:0]          pb_b_reg [NUM_ROWS];
    logic signed [SW-1:0]          pb_b_next [NUM_ROWS];
    logic signed [RW-1:0]          row_c_reg [NUM_ROWS];
    logic signed [RW-1:0]          row_c_next [NUM_ROWS];
    logic [RW-1:0]                 row_d_reg [NUM_LANES];
    logic [RW-1:0]                 mag_d_reg [NUM_LANES];
    logic [RW-1:0]                 mag_d_next [NUM_LANES];
    logic [RW-1:0]                 den_d_reg, den_d_next;
    logic                          den_neg_d_reg;

    logic load_en;
    logic is_point;

    assign load_en  = take && (req_type == REQ_LOAD);
    assign is_point = (req_type == REQ_POINT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (load_en)
        begin
            store_reg[entry_index] <= entry_value;
        end
    end

    // Stage A: every product of a matrix entry and a coordinate.
    always_comb
    begin
        coord[0] = coord_x;
        coord[1] = coord_y;
        coord[2] = coord_z;
        ctrl_a_next.valid  = take && (is_point || (req_type == REQ_DIRECTION));
        ctrl_a_next.point  = is_point;
        ctrl_a_next.divide = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int j = 0; j < NUM_LANES; j++)
            begin
                prod_a_next[r][j] = PW'(store_reg[r*NUM_COLS+j]) * PW'(coord[j]);
            end
            trans_a_next[r] = is_point ? store_reg[r*NUM_COLS+NUM_LANES] : '0;
        end
    end

    // Stage B: pairwise sums, translation brought to the product scale.
    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            pa_b_next[r] = SW'(prod_a_reg[r][0]) + SW'(prod_a_reg[r][1]);
            pb_b_next[r] = SW'(prod_a_reg[r][2]) + (SW'(trans_a_reg[r]) <<< FRAC_BITS);
        end
    end

    // Stage C: row sum, back to FRAC_BITS fraction bits (floor).
    always_comb
    begin
        logic signed [SW-1:0] sum;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            sum           = pa_b_reg[r] + pb_b_reg[r];
            row_c_next[r] = RW'(sum >>> FRAC_BITS);
        end
    end

    // Stage D: divide decision and magnitudes for the divider.
    always_comb
    begin
        ctrl_d_next        = ctrl_c_reg;
        ctrl_d_next.divide = ctrl_c_reg.point && (row_c_reg[W_ROW] != '0);
        for (int k = 0; k < NUM_LANES; k++)
        begin
            mag_d_next[k] = row_c_reg[k][RW-1] ? RW'(-row_c_reg[k]) : RW'(row_c_reg[k]);
        end
        den_d_next = row_c_reg[W_ROW][RW-1] ? RW'(-row_c_reg[W_ROW]) : RW'(row_c_reg[W_ROW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
            ctrl_d_reg <= '0;
        end
        else if (en)
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_a_reg;
            ctrl_c_reg <= ctrl_b_reg;
            ctrl_d_reg <= ctrl_d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg  <= prod_a_next;
            trans_a_reg <= trans_a_next;
            pa_b_reg    <= pa_b_next;
            pb_b_reg    <= pb_b_next;
            row_c_reg   <= row_c_next;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                row_d_reg[k] <= row_c_reg[k];
            end
            mag_d_reg     <= mag_d_next;
            den_d_reg     <= den_d_next;
            den_neg_d_reg <= row_c_reg[W_ROW][RW-1];
        end
    end

    assign ctrl_out    = ctrl_d_reg;
    assign row_out     = row_d_reg;
    assign mag_out     = mag_d_reg;
    assign den_out     = den_d_reg;
    assign den_neg_out = den_neg_d_reg;

endmodule

`default_nettype wire

[hdl/hpt_div.sv]
// Pipelined restoring divider for the three lanes, one quotient bit per stage.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpt_div #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  hpt_pkg::hpt_ctrl_t                  ctrl_in,
    input  logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] row_in [hpt_pkg::NUM_LANES],
    input  logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] mag_in [hpt_pkg::NUM_LANES],
    input  logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] den_in,
    input  logic                                den_neg_in,
    output hpt_pkg::hpt_ctrl_t                  ctrl_out,
    output logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] row_out [hpt_pkg::NUM_LANES],
    output logic [VALUE_WIDTH-1:0]              quo_out [hpt_pkg::NUM_LANES],
    output logic                                ovf_out [hpt_pkg::NUM_LANES],
    output logic                                neg_out [hpt_pkg::NUM_LANES]
);
    import hpt_pkg::*;

    localparam int SW = 2 * VALUE_WIDTH + 2;
    localparam int RW = SW - FRAC_BITS;
    localparam int QW = VALUE_WIDTH;

    hpt_ctrl_t        ctrl_reg [QW+1];
    logic [RW-1:0]    den_reg  [QW+1];
    logic [RW-1:0]    row_reg  [QW+1][NUM_LANES];
    logic [RW-1:0]    rem_reg  [QW+1][NUM_LANES];
    logic [QW-1:0]    low_reg  [QW+1][NUM_LANES];
    logic [QW-1:0]    quo_reg  [QW+1][NUM_LANES];
    logic             ovf_reg  [QW+1][NUM_LANES];
    logic             neg_reg  [QW+1][NUM_LANES];

    logic [SW-1:0]    num0     [NUM_LANES];

    // Set-up stage: the quotient fits QW bits only if the top of the
    // dividend is below the divisor; otherwise the lane saturates.
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            num0[k] = SW'(mag_in[k]) << FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg[0] <= '0;
        end
        else if (en)
        begin
            ctrl_reg[0] <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den_in;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                row_reg[0][k] <= row_in[k];
                rem_reg[0][k] <= RW'(num0[k] >> QW);
                low_reg[0][k] <= num0[k][QW-1:0];
                quo_reg[0][k] <= '0;
                ovf_reg[0][k] <= (num0[k] >> QW) >= SW'(den_in);
                neg_reg[0][k] <= row_in[k][RW-1] ^ den_neg_in;
            end
        end
    end

    for (genvar s = 1; s <= QW; s++)
    begin : g_step
        logic [RW-1:0] rem_next [NUM_LANES];
        logic          bit_next [NUM_LANES];

        always_comb
        begin
            logic [RW:0] trial;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                trial       = {rem_reg[s-1][k], low_reg[s-1][k][QW-1]};
                bit_next[k] = trial >= {1'b0, den_reg[s-1]};
                rem_next[k] = bit_next[k] ? RW'(trial - {1'b0, den_reg[s-1]}) : RW'(trial);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[s] <= '0;
            end
            else if (en)
            begin
                ctrl_reg[s] <= ctrl_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[s] <= den_reg[s-1];
                for (int k = 0; k < NUM_LANES; k++)
                begin
                    row_reg[s][k] <= row_reg[s-1][k];
                    rem_reg[s][k] <= rem_next[k];
                    low_reg[s][k] <= low_reg[s-1][k] << 1;
                    quo_reg[s][k] <= {quo_reg[s-1][k][QW-2:0], bit_next[k]};
                    ovf_reg[s][k] <= ovf_reg[s-1][k];
                    neg_reg[s][k] <= neg_reg[s-1][k];
                end
            end
        end
    end

    assign ctrl_out = ctrl_reg[QW];

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            row_out[k] = row_reg[QW][k];
            quo_out[k] = quo_reg[QW][k];
            ovf_out[k] = ovf_reg[QW][k];
            neg_out[k] = neg_reg[QW][k];
        end
    end

endmodule

`default_nettype wire

[hdl/hpt_sat.sv]
// Saturation of the three lanes and the output register of the transform.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpt_sat #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  hpt_pkg::hpt_ctrl_t                  ctrl_in,
    input  logic [2*VALUE_WIDTH+2-FRAC_BITS-1:0] row_in [hpt_pkg::NUM_LANES],
    input  logic [VALUE_WIDTH-1:0]              quo_in [hpt_pkg::NUM_LANES],
    input  logic                                ovf_in [hpt_pkg::NUM_LANES],
    input  logic                                neg_in [hpt_pkg::NUM_LANES],
    output logic                                res_valid,
    output logic signed [VALUE_WIDTH-1:0]       out_x,
    output logic signed [VALUE_WIDTH-1:0]       out_y,
    output logic signed [VALUE_WIDTH-1:0]       out_z,
    output logic                                was_divided,
    output logic                                overflow
);
    import hpt_pkg::*;

    localparam int RW = 2 * VALUE_WIDTH + 2 - FRAC_BITS;
    localparam int VW = VALUE_WIDTH;

    localparam logic [VW-1:0] MAX_Q = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] MIN_Q = {1'b1, {(VW-1){1'b0}}};
    localparam logic [RW-1:0] MAX_R = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [RW-1:0] MIN_R = {{(RW-VW+1){1'b1}}, {(VW-1){1'b0}}};

    logic [VW-1:0] val_next [NUM_LANES];
    logic          sat_next [NUM_LANES];

    logic          valid_reg;
    logic [VW-1:0] val_reg [NUM_LANES];
    logic          div_reg, ovf_reg;

    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            if (ctrl_in.divide)
            begin
                sat_next[k] = ovf_in[k] || (neg_in[k] ? (quo_in[k] > MIN_Q)
                                                      : (quo_in[k] > MAX_Q));
                if (sat_next[k])
                begin
                    val_next[k] = neg_in[k] ? MIN_Q : MAX_Q;
                end
                else
                begin
                    val_next[k] = neg_in[k] ? VW'('0 - quo_in[k]) : quo_in[k];
                end
            end
            else
            begin
                if ($signed(row_in[k]) > $signed(MAX_R))
                begin
                    sat_next[k] = 1'b1;
                    val_next[k] = MAX_Q;
                end
                else if ($signed(row_in[k]) < $signed(MIN_R))
                begin
                    sat_next[k] = 1'b1;
                    val_next[k] = MIN_Q;
                end
                else
                begin
                    sat_next[k] = 1'b0;
                    val_next[k] = row_in[k][VW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            div_reg <= ctrl_in.divide;
            ovf_reg <= sat_next[0] || sat_next[1] || sat_next[2];
        end
    end

    assign res_valid   = valid_reg;
    assign out_x       = val_reg[0];
    assign out_y       = val_reg[1];
    assign out_z       = val_reg[2];
    assign was_divided = div_reg;
    assign overflow    = ovf_reg;

endmodule

`default_nettype wire

[hdl/homogeneous_point_transform.sv]
// Top level of the homogeneous 4x4 point transform: matrix store, MAC stages,
// pipelined divider and saturating output register. Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block holds a 4x4 signed fixed-point matrix (VALUE_WIDTH bits with
// FRAC_BITS fraction bits, Q16.16 by default), cleared to zero at reset. A
// load item writes one entry (row times four plus column) and gives no
// result; it takes effect for the very next item. A point item computes
// (x, y, z, 1) against the matrix; when the resulting w is nonzero, x, y and
// z are divided by w with the quotient truncated toward zero and was_divided
// is set, otherwise they come back undivided. A direction item uses the upper
// 3x3 part only and is never divided. Every component saturates to the
// signed range and overflow flags any saturation. A request type of three is
// dropped. One item is accepted in every cycle in which res_ready is high or
// the output register is empty; the first register of an item is loaded at
// the edge that accepts it. The item then passes four multiply-accumulate
// stages and one divider set-up stage, then the restoring divider, which
// resolves one quotient bit per stage, and last the output register. When
// the output is stalled the whole pipeline holds, so nothing is lost or
// repeated.
module homogeneous_point_transform #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [hpt_pkg::REQ_TYPE_W-1:0]  req_type,
    input  logic [hpt_pkg::ENTRY_IDX_W-1:0] entry_index,
    input  logic signed [VALUE_WIDTH-1:0]   entry_value,
    input  logic signed [VALUE_WIDTH-1:0]   coord_x,
    input  logic signed [VALUE_WIDTH-1:0]   coord_y,
    input  logic signed [VALUE_WIDTH-1:0]   coord_z,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic signed [VALUE_WIDTH-1:0]   out_x,
    output logic signed [VALUE_WIDTH-1:0]   out_y,
    output logic signed [VALUE_WIDTH-1:0]   out_z,
    output logic                            was_divided,
    output logic                            overflow
);
    import hpt_pkg::*;

    localparam int RW = 2 * VALUE_WIDTH + 2 - FRAC_BITS;

    // The pipeline moves whenever the output register is free or being
    // emptied this cycle; every stage shares this one enable.
    logic en;
    logic take;

    hpt_ctrl_t     mac_ctrl;
    logic [RW-1:0] mac_row [NUM_LANES];
    logic [RW-1:0] mac_mag [NUM_LANES];
    logic [RW-1:0] mac_den;
    logic          mac_den_neg;

    hpt_ctrl_t          div_ctrl;
    logic [RW-1:0]          div_row [NUM_LANES];
    logic [VALUE_WIDTH-1:0] div_quo [NUM_LANES];
    logic                   div_ovf [NUM_LANES];
    logic                   div_neg [NUM_LANES];

    assign en        = !res_valid || res_ready;
    assign req_ready = en;
    assign take      = req_valid && en;

    hpt_mac #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .take        (take),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .ctrl_out    (mac_ctrl),
        .row_out     (mac_row),
        .mag_out     (mac_mag),
        .den_out     (mac_den),
        .den_neg_out (mac_den_neg)
    );

    hpt_div #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctrl_in    (mac_ctrl),
        .row_in     (mac_row),
        .mag_in     (mac_mag),
        .den_in     (mac_den),
        .den_neg_in (mac_den_neg),
        .ctrl_out   (div_ctrl),
        .row_out    (div_row),
        .quo_out    (div_quo),
        .ovf_out    (div_ovf),
        .neg_out    (div_neg)
    );

    hpt_sat #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_sat (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctrl_in     (div_ctrl),
        .row_in      (div_row),
        .quo_in      (div_quo),
        .ovf_in      (div_ovf),
        .neg_in      (div_neg),
        .res_valid   (res_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .was_divided (was_divided),
        .overflow    (overflow)
    );

endmodule

`default_nettype wire

[hdl/hpt_checker.sv]
// Port-level checker of the homogeneous point transform and its bind.
// Depends on homogeneous_point_transform_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "homogeneous_point_transform_macros.svh"

module hpt_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   req_valid,
    input wire                   req_ready,
    input wire                   res_valid,
    input wire                   res_ready,
    input wire [VALUE_WIDTH-1:0] out_x,
    input wire [VALUE_WIDTH-1:0] out_y,
    input wire [VALUE_WIDTH-1:0] out_z
);

    // An empty output register must never hold back the input.
    `HPT_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !res_valid, req_ready)

    // A result being taken frees the pipeline for a new item.
    `HPT_ASSERT_IMP(a_ready_when_drained, clk, rst_n, res_ready, req_ready)

    // A stalled result keeps its values.
    `HPT_ASSERT_NXT(a_result_holds, clk, rst_n, res_valid && !res_ready,
        res_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))

    // With the input stalled the output must be the stalled side.
    `HPT_ASSERT_IMP(a_stall_cause, clk, rst_n, req_valid && !req_ready,
        res_valid && !res_ready)

endmodule

bind homogeneous_point_transform hpt_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_hpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
);

`default_nettype wire
